### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the top level of the timed release queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed release queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timed release queue: next-cycle check failed");

`endif

### rtl/core/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg
// Shared types and codes of the timed release queue.
// ----------------------------------------------------------------------------
package trq_pkg;

    // Request kinds as they arrive on the input channel.
    localparam logic [1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TIME_OFFSET   = 1'b0;
    localparam logic CFG_PATTERN_COUNT = 1'b1;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 2;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_SCHEDULE,
        OP_TICK,
        OP_CLEAR
    } t_op;

    // One classified command. The value is the release time of a schedule
    // request or the relative time of a tick.
    typedef struct packed {
        t_op         op;
        logic [7:0]  index;
        logic [31:0] value;
    } t_cmd;

    // Status of the back end, observed at the top level.
    typedef struct packed {
        logic releasing;
        logic pend_valid;
    } t_back_status;

endpackage

### rtl/core/trq_front.sv
// ----------------------------------------------------------------------------
// trq_front
// Holds the configuration registers, screens incoming requests and turns
// them into commands for the back end.
// ----------------------------------------------------------------------------
module trq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_pattern_index,
    input  logic [31:0]       i_release_time,
    input  logic [31:0]       i_current_time,
    input  logic              i_cmd_full,
    output logic              o_stall,
    output logic              o_push,
    output trq_pkg::t_cmd     o_cmd
);

    logic [31:0] r_time_offset;
    logic [7:0]  r_pattern_count;
    logic        keep;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_offset   <= '0;
            r_pattern_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                trq_pkg::CFG_TIME_OFFSET:   r_time_offset   <= i_cfg_data;
                trq_pkg::CFG_PATTERN_COUNT: r_pattern_count <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Classify the request. Schedules with an index out of range and the
    // unused kind are dropped here; ticks carry their relative time.
    always_comb begin
        keep        = 1'b0;
        o_cmd.op    = trq_pkg::OP_CLEAR;
        o_cmd.index = i_pattern_index;
        o_cmd.value = i_release_time;
        unique case (i_kind)
            trq_pkg::KIND_SCHEDULE: begin
                keep     = (i_pattern_index < r_pattern_count);
                o_cmd.op = trq_pkg::OP_SCHEDULE;
            end
            trq_pkg::KIND_TICK: begin
                keep        = 1'b1;
                o_cmd.op    = trq_pkg::OP_TICK;
                o_cmd.value = i_current_time - r_time_offset;
            end
            trq_pkg::KIND_CLEAR: begin
                keep     = 1'b1;
                o_cmd.op = trq_pkg::OP_CLEAR;
            end
            default: keep = 1'b0;
        endcase
    end

    // Requests are taken whenever the command queue has room.
    assign o_stall = i_cmd_full;
    assign o_push  = i_valid && !i_cmd_full && keep;

endmodule

### rtl/core/trq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// trq_cmd_fifo
// Two-entry command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module trq_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trq_pkg::t_cmd     i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output trq_pkg::t_cmd     o_cmd
);

    localparam int CW = $clog2(trq_pkg::CMD_DEPTH + 1);

    trq_pkg::t_cmd r_slot [trq_pkg::CMD_DEPTH];
    logic          r_wptr;
    logic          r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(trq_pkg::CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rptr];

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### rtl/core/trq_back.sv
// ----------------------------------------------------------------------------
// trq_back
// Holds scheduled entries in a circular store and carries out schedule, clear
// and tick commands. A tick releases due entries one per cycle unless stalled.
// ----------------------------------------------------------------------------
module trq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  trq_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_fired_index,
    output logic                  o_last,
    output trq_pkg::t_back_status o_status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } t_state;

    // Entry store.
    logic [7:0]  r_mem_index [QUEUE_DEPTH];
    logic [31:0] r_mem_time  [QUEUE_DEPTH];

    t_state        r_state,      n_state;
    logic [PW-1:0] r_head,       n_head;
    logic [PW-1:0] r_tail,       n_tail;
    logic [CW-1:0] r_count,      n_count;
    logic [31:0]   r_now,        n_now;
    logic          r_pend_valid, n_pend_valid;
    logic [7:0]    r_pend_idx,   n_pend_idx;
    logic          r_out_valid,  n_out_valid;
    logic [7:0]    r_out_idx,    n_out_idx;
    logic          r_out_last,   n_out_last;

    logic          wr_en;
    logic          head_due;
    logic          out_free;
    logic          out_load;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    assign head_inc = (r_head == LAST_PTR) ? '0 : r_head + PW'(1);
    assign tail_inc = (r_tail == LAST_PTR) ? '0 : r_tail + PW'(1);
    assign head_due = (r_count != '0) && (r_mem_time[r_head] < r_now);
    assign out_free = !r_out_valid || !i_stall;

    // Command execution and the release sequence.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_now        = r_now;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        o_cmd_pop    = 1'b0;
        wr_en        = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        trq_pkg::OP_SCHEDULE: begin
                            if (r_count != CW'(QUEUE_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_tail  = tail_inc;
                                n_count = r_count + CW'(1);
                            end
                        end
                        trq_pkg::OP_TICK: begin
                            n_now   = i_cmd.value;
                            n_state = ST_RELEASE;
                        end
                        trq_pkg::OP_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RELEASE: begin
                // One entry is held back until we know whether it is the
                // last one released by this tick.
                if (head_due) begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            out_load   = 1'b1;
                            n_out_idx  = r_pend_idx;
                            n_out_last = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_mem_index[r_head];
                        n_head       = head_inc;
                        n_count      = r_count - CW'(1);
                    end
                end else if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    n_out_idx    = r_pend_idx;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = out_load || (r_out_valid && i_stall);
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_now        <= '0;
            r_pend_valid <= 1'b0;
            r_pend_idx   <= '0;
            r_out_valid  <= 1'b0;
            r_out_idx    <= '0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_now        <= n_now;
            r_pend_valid <= n_pend_valid;
            r_pend_idx   <= n_pend_idx;
            r_out_valid  <= n_out_valid;
            r_out_idx    <= n_out_idx;
            r_out_last   <= n_out_last;
        end
    end

    // Entry store writes at the tail.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_index[r_tail] <= i_cmd.index;
            r_mem_time[r_tail]  <= i_cmd.value;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_fired_index       = r_out_idx;
    assign o_last              = r_out_last;
    assign o_status.releasing  = (r_state == ST_RELEASE);
    assign o_status.pend_valid = r_pend_valid;

endmodule

### rtl/core/timed_release_queue.sv
// ----------------------------------------------------------------------------
// timed_release_queue
// FIFO of scheduled pattern plays that are released by time ticks.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_kind, i_pattern_index,
//                                         i_release_time, i_current_time
// result    out        o_valid / i_stall  o_fired_index, o_last
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// Requests enter a two-entry command queue; o_stall is high only while it is
// full. Schedule and clear commands are carried out in the back end's idle
// state. A tick starts a release loop that reads one entry per cycle from the
// entry store; a stalled result register holds the loop. Synchronous
// active-low reset empties both queues.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_release_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_pattern_index,
    input  logic [31:0] i_release_time,
    input  logic [31:0] i_current_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_fired_index,
    output logic        o_last
);

    logic                  push;
    logic                  cmd_full;
    logic                  cmd_valid;
    logic                  cmd_pop;
    trq_pkg::t_cmd         front_cmd;
    trq_pkg::t_cmd         back_cmd;
    trq_pkg::t_back_status status;

    // Front end: configuration and request screening.
    trq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_kind          (i_kind),
        .i_pattern_index (i_pattern_index),
        .i_release_time  (i_release_time),
        .i_current_time  (i_current_time),
        .i_cmd_full      (cmd_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Command queue between the two halves.
    trq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd)
    );

    // Back end: entry store and release sequence.
    trq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (back_cmd),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fired_index (o_fired_index),
        .o_last        (o_last),
        .o_status      (status)
    );

    // A held-back entry exists only while a tick is being worked off.
    `ASSERT_SAME_CYCLE(a_pend_only_releasing, i_clk, i_rst_n,
        !status.releasing, !status.pend_valid)

    // Once a result that is not the last is taken, the next one follows.
    `ASSERT_NEXT_CYCLE(a_burst_continues, i_clk, i_rst_n,
        o_valid && !o_last && !i_stall, o_valid)

    // A result that is not the last implies a held-back entry behind it.
    `ASSERT_SAME_CYCLE(a_non_last_has_pend, i_clk, i_rst_n,
        o_valid && !o_last, status.pend_valid)

endmodule

### tb/sv/tb_timed_release_queue.sv
// ----------------------------------------------------------------------------
// tb_timed_release_queue
// Self-checking testbench of the timed release queue.
// ----------------------------------------------------------------------------
// Schedule, tick, clear and unused requests are queued by a stimulus process.
// A clocked driver feeds them to the block with random gaps. A clocked monitor
// keeps a model of the held entries that advances on every accepted request,
// and checks each released entry against the oldest predicted one. Runs go
// through several offset and pattern-count settings; the driver idles and the
// result channel stalls at random except during one quiet phase.
// ----------------------------------------------------------------------------
module tb_timed_release_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QDEPTH        = 16;
    localparam int          IDLE_PCT      = 27;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          MAX_REPORTS   = 10;
    localparam int          TIMEOUT_NS    = 4_000_000;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  pidx;
        logic [31:0] rtime;
        logic [31:0] ctime;
    } t_req;

    typedef struct {
        logic [7:0] index;
        logic       last;
    } t_fire;

    // Block ports.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_index     = 1'b0;
    logic [31:0] i_cfg_data      = '0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind          = '0;
    logic [7:0]  i_pattern_index = '0;
    logic [31:0] i_release_time  = '0;
    logic [31:0] i_current_time  = '0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [7:0]  o_fired_index;
    logic        o_last;

    // Model of the queue contents and registers.
    logic [7:0]  held_idx [QDEPTH];
    logic [31:0] held_time [QDEPTH];
    int          held_cnt   = 0;
    logic [31:0] cfg_offset = '0;
    logic [7:0]  cfg_count  = '0;

    // Requests waiting to be driven and entries waiting to be released.
    t_req        pending_q[$];
    t_fire       fired_q[$];
    t_req        next_req;
    t_fire       due_fire;

    logic        req_taken    = 1'b0;
    logic        quiet        = 1'b0;
    logic [31:0] rel_now      = '0;
    int          err_cnt      = 0;
    int          accepted_cnt = 0;
    int          tick_cnt     = 0;
    int          checked_cnt  = 0;

    timed_release_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_pattern_index(i_pattern_index),
        .i_release_time (i_release_time),
        .i_current_time (i_current_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_fired_index  (o_fired_index),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Update the held entries for one accepted request and queue the entries
    // that a tick releases, the final one marked as last.
    function automatic void predict_request(logic [1:0] kind, logic [7:0] pidx,
                                            logic [31:0] rtime, logic [31:0] ctime);
        logic [31:0] now;
        int          popped;
        t_fire       f;
        now    = ctime - cfg_offset;
        popped = 0;
        case (kind)
            trq_pkg::KIND_SCHEDULE: begin
                if (pidx < cfg_count && held_cnt < QDEPTH) begin
                    held_idx[held_cnt]  = pidx;
                    held_time[held_cnt] = rtime;
                    held_cnt++;
                end
            end
            trq_pkg::KIND_TICK: begin
                while (popped < held_cnt && held_time[popped] < now) begin
                    f.index = held_idx[popped];
                    f.last  = 1'b0;
                    fired_q.push_back(f);
                    popped++;
                end
                if (popped != 0) begin
                    fired_q[fired_q.size() - 1].last = 1'b1;
                    for (int k = 0; k + popped < held_cnt; k++) begin
                        held_idx[k]  = held_idx[k + popped];
                        held_time[k] = held_time[k + popped];
                    end
                    held_cnt -= popped;
                end
            end
            trq_pkg::KIND_CLEAR: begin
                held_cnt = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // Request driver: holds a stalled request, otherwise moves on or idles.
    always @(negedge i_clk) begin
        if (i_valid && !req_taken) begin
            i_valid <= 1'b1;
        end else if (pending_q.size() != 0 &&
                     (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_req        = pending_q.pop_front();
            i_valid         <= 1'b1;
            i_kind          <= next_req.kind;
            i_pattern_index <= next_req.pidx;
            i_release_time  <= next_req.rtime;
            i_current_time  <= next_req.ctime;
        end else begin
            i_valid <= 1'b0;
        end
        i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: predicts on accepted requests and checks released entries.
    always @(posedge i_clk) begin
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                req_taken = 1'b1;
                accepted_cnt++;
                if (i_kind == trq_pkg::KIND_TICK) tick_cnt++;
                predict_request(i_kind, i_pattern_index, i_release_time, i_current_time);
            end
            if (o_valid && !i_stall) begin
                checked_cnt++;
                if (fired_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected release: index %0d last %0d",
                                 o_fired_index, o_last);
                end else begin
                    due_fire = fired_q.pop_front();
                    if (o_fired_index !== due_fire.index || o_last !== due_fire.last) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"release mismatch: index exp %0d got %0d, ",
                                      "last exp %0d got %0d"},
                                     due_fire.index, o_fired_index, due_fire.last, o_last);
                    end
                end
            end
        end
    end

    task automatic add_item(input logic [1:0] kind, input logic [7:0] pidx,
                            input logic [31:0] rtime, input logic [31:0] ctime);
        t_req r;
        r.kind  = kind;
        r.pidx  = pidx;
        r.rtime = rtime;
        r.ctime = ctime;
        pending_q.push_back(r);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == trq_pkg::CFG_TIME_OFFSET) cfg_offset = data;
        else cfg_count = data[7:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every release has come, then let
    // the command queue and back end settle.
    task automatic wait_idle();
        while (pending_q.size() != 0 || i_valid || fired_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic: mostly schedules close to the running time and ticks
    // that advance it, with some out-of-range values, clears and unused kinds.
    task automatic run_random(input int n_items, input logic [31:0] start_time);
        int          roll;
        logic [7:0]  pidx;
        logic [31:0] rtime;
        logic [31:0] ctime;
        rel_now = start_time;
        for (int n = 0; n < n_items; n++) begin
            roll  = $urandom_range(0, 99);
            pidx  = 8'($urandom);
            rtime = $urandom;
            ctime = $urandom;
            if (roll < 55) begin
                if (cfg_count != 0 && $urandom_range(0, 9) != 0)
                    pidx = 8'($urandom_range(0, cfg_count - 1));
                if ($urandom_range(0, 15) != 0)
                    rtime = rel_now + $urandom_range(0, 40);
                add_item(trq_pkg::KIND_SCHEDULE, pidx, rtime, ctime);
            end else if (roll < 93) begin
                rel_now += $urandom_range(0, 24);
                if ($urandom_range(0, 19) != 0)
                    ctime = rel_now + cfg_offset;
                add_item(trq_pkg::KIND_TICK, pidx, rtime, ctime);
            end else if (roll < 97) begin
                add_item(trq_pkg::KIND_CLEAR, pidx, rtime, ctime);
            end else begin
                add_item(KIND_UNUSED, pidx, rtime, ctime);
            end
        end
        wait_idle();
    endtask

    // Stimulus sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: every schedule is dropped and nothing fires.
        add_item(trq_pkg::KIND_SCHEDULE, 8'd0, 32'd0, 32'd0);
        add_item(trq_pkg::KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(KIND_UNUSED, 8'hA5, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        wait_idle();

        // Fill the queue to the top, with an index out of range and an extra
        // schedule that finds it full; the last entry is never due.
        write_reg(trq_pkg::CFG_TIME_OFFSET, 32'd0);
        write_reg(trq_pkg::CFG_PATTERN_COUNT, {24'($urandom), 8'd255});
        add_item(trq_pkg::KIND_SCHEDULE, 8'd255, 32'd0, 32'd0);
        for (int k = 0; k < QDEPTH - 1; k++)
            add_item(trq_pkg::KIND_SCHEDULE, 8'(k * 17), 32'(k * 3), 32'd0);
        add_item(trq_pkg::KIND_SCHEDULE, 8'd254, 32'hFFFF_FFFF, 32'd0);
        add_item(trq_pkg::KIND_SCHEDULE, 8'd1, 32'd0, 32'd0);
        // Equal times are not yet due; the top of the range releases all but one.
        add_item(trq_pkg::KIND_TICK, 8'd0, 32'd0, 32'd0);
        add_item(trq_pkg::KIND_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        add_item(trq_pkg::KIND_CLEAR, 8'd0, 32'd0, 32'd0);
        add_item(trq_pkg::KIND_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        wait_idle();

        // Largest offset, a single pattern, time wrapping past the top.
        write_reg(trq_pkg::CFG_TIME_OFFSET, 32'hFFFF_FFFF);
        write_reg(trq_pkg::CFG_PATTERN_COUNT, {24'($urandom), 8'd1});
        run_random(60, 32'hFFFF_FF80);

        // Random settings with no idling on either side.
        quiet = 1'b1;
        write_reg(trq_pkg::CFG_TIME_OFFSET, $urandom);
        write_reg(trq_pkg::CFG_PATTERN_COUNT,
                  {24'($urandom), 8'($urandom_range(2, 254))});
        run_random(70, $urandom >> 1);
        quiet = 1'b0;

        write_reg(trq_pkg::CFG_TIME_OFFSET, $urandom);
        write_reg(trq_pkg::CFG_PATTERN_COUNT, {24'($urandom), 8'd255});
        run_random(80, $urandom >> 1);

        // No patterns loaded: every schedule is dropped.
        write_reg(trq_pkg::CFG_PATTERN_COUNT, {24'($urandom), 8'd0});
        run_random(20, $urandom >> 1);

        write_reg(trq_pkg::CFG_TIME_OFFSET, 32'd0);
        write_reg(trq_pkg::CFG_PATTERN_COUNT, {24'($urandom), 8'd16});
        run_random(55, $urandom >> 1);

        $display("Covered %0d requests (%0d ticks) over the reset values and six written settings.",
                 accepted_cnt, tick_cnt);
        $display("Checked %0d released entries, %0d mismatches.", checked_cnt, err_cnt);
        if (err_cnt == 0 && fired_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #TIMEOUT_NS;
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/trq_pkg.sv
rtl/core/trq_front.sv
rtl/core/trq_cmd_fifo.sv
rtl/core/trq_back.sv
rtl/core/timed_release_queue.sv
tb/sv/tb_timed_release_queue.sv
